// ===== rtl/pblw_pkg.sv =====
// pblw_pkg: shared widths, codes and controller/datapath interface types
// for the page buffer pool tag and policy controller
// no dependencies
`default_nettype none

package pblw_pkg;

    localparam int MODE_W          = 2;
    localparam int FILE_W          = 8;
    localparam int PAGE_W          = 24;
    localparam int KIND_W          = 3;
    localparam int ENTRY_W         = 2;
    localparam int DEF_NUM_ENTRIES = 4;

    typedef enum logic [MODE_W-1:0] {
        MODE_READ  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_FLUSH = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_HIT        = 3'd0,
        KIND_WRITEBACK  = 3'd1,
        KIND_FILL       = 3'd2,
        KIND_TAKE       = 3'd3,
        KIND_FLUSH_DONE = 3'd4
    } kind_t;

    // controller to datapath
    typedef struct packed {
        logic latch_req;
        logic do_lookup;
        logic emit_hit;
        logic emit_lru_wb;
        logic emit_place;
        logic emit_flush_wb;
        logic emit_flush_done;
        logic walk_clear;
        logic walk_inc;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        mode_t in_mode;
        logic  hit;
        logic  all_dirty;
        logic  walk_match;
        logic  walk_last;
        logic  out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/pblw_datapath.sv =====
// pblw_datapath: entry tags, dirty and recency state, lookup and victim
// choice, flush walk and the result register
// depends on pblw_pkg
`default_nettype none

module pblw_datapath #(
    parameter int NUM_ENTRIES = pblw_pkg::DEF_NUM_ENTRIES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pblw_pkg::cmd_t              cmd,
    output pblw_pkg::status_t           status,
    input  logic [pblw_pkg::MODE_W-1:0] mode,
    input  logic [pblw_pkg::FILE_W-1:0] file_id,
    input  logic [pblw_pkg::PAGE_W-1:0] page_number,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [pblw_pkg::KIND_W-1:0] kind,
    output logic [pblw_pkg::ENTRY_W-1:0] entry,
    output logic [pblw_pkg::FILE_W-1:0] target_file,
    output logic [pblw_pkg::PAGE_W-1:0] target_page,
    output logic                        last
);
    import pblw_pkg::*;

    localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_RANK = IDX_W'(NUM_ENTRIES - 1);

    // entry state
    logic [NUM_ENTRIES-1:0] valid_reg, valid_next;
    logic [NUM_ENTRIES-1:0] dirty_reg, dirty_next;
    logic [FILE_W-1:0]      file_reg [NUM_ENTRIES];
    logic [FILE_W-1:0]      file_next [NUM_ENTRIES];
    logic [PAGE_W-1:0]      page_reg [NUM_ENTRIES];
    logic [PAGE_W-1:0]      page_next [NUM_ENTRIES];
    logic [IDX_W-1:0]       rank_reg [NUM_ENTRIES];
    logic [IDX_W-1:0]       rank_next [NUM_ENTRIES];

    // current request and lookup results
    mode_t                  req_mode_reg;
    logic [FILE_W-1:0]      req_file_reg;
    logic [PAGE_W-1:0]      req_page_reg;
    logic [NUM_ENTRIES-1:0] hit_vec_reg, hit_vec_next;
    logic                   hit_reg, hit_next;
    logic                   all_dirty_reg, all_dirty_next;
    logic [IDX_W-1:0]       vrank_reg, vrank_next;
    logic [IDX_W-1:0]       walk_reg, walk_next;

    // result register
    logic                   out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]      kind_reg, kind_next;
    logic [ENTRY_W-1:0]     entry_reg, entry_next;
    logic [FILE_W-1:0]      tfile_reg, tfile_next;
    logic [PAGE_W-1:0]      tpage_reg, tpage_next;
    logic                   last_reg, last_next;

    logic [NUM_ENTRIES-1:0] file_eq, hit_vec, vict_sel, walk_sel, front_sel;
    logic [NUM_ENTRIES-1:0] clean_by_rank;
    logic [IDX_W-1:0]       first_clean;
    logic                   clean_found;
    logic [IDX_W-1:0]       hit_idx, vict_idx, walk_idx, front_rank;
    logic [FILE_W-1:0]      vict_file, walk_file;
    logic [PAGE_W-1:0]      vict_page, walk_page;
    logic                   req_write, move_en, emit_any;

    assign req_write = (req_mode_reg == MODE_WRITE);

    // per-entry compares and selects
    always_comb
    begin
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            file_eq[i]  = valid_reg[i] && (file_reg[i] == req_file_reg);
            hit_vec[i]  = file_eq[i] && (page_reg[i] == req_page_reg);
            vict_sel[i] = (rank_reg[i] == vrank_reg);
            walk_sel[i] = (rank_reg[i] == walk_reg);
        end
    end

    // clean flags rearranged into recency order
    always_comb
    begin
        clean_by_rank = '0;
        for (int r = 0; r < NUM_ENTRIES; r++)
        begin
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                if ((rank_reg[i] == IDX_W'(r)) && !dirty_reg[i])
                begin
                    clean_by_rank[r] = 1'b1;
                end
            end
        end
    end

    // most recent clean entry
    always_comb
    begin
        first_clean = '0;
        clean_found = 1'b0;
        for (int r = NUM_ENTRIES - 1; r >= 0; r--)
        begin
            if (clean_by_rank[r])
            begin
                first_clean = IDX_W'(r);
                clean_found = 1'b1;
            end
        end
    end

    // one-hot to index and field muxes
    always_comb
    begin
        hit_idx   = '0;
        vict_idx  = '0;
        walk_idx  = '0;
        vict_file = '0;
        vict_page = '0;
        walk_file = '0;
        walk_page = '0;
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            if (hit_vec_reg[i])
            begin
                hit_idx = hit_idx | IDX_W'(i);
            end
            if (vict_sel[i])
            begin
                vict_idx  = vict_idx | IDX_W'(i);
                vict_file = vict_file | file_reg[i];
                vict_page = vict_page | page_reg[i];
            end
            if (walk_sel[i])
            begin
                walk_idx  = walk_idx | IDX_W'(i);
                walk_file = walk_file | file_reg[i];
                walk_page = walk_page | page_reg[i];
            end
        end
    end

    assign front_sel = cmd.emit_hit ? hit_vec_reg : vict_sel;
    assign move_en   = cmd.emit_hit | cmd.emit_place;

    always_comb
    begin
        front_rank = '0;
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            if (front_sel[i])
            begin
                front_rank = front_rank | rank_reg[i];
            end
        end
    end

    // entry state update
    always_comb
    begin
        valid_next = valid_reg;
        dirty_next = dirty_reg;
        file_next  = file_reg;
        page_next  = page_reg;
        rank_next  = rank_reg;
        if (cmd.emit_lru_wb)
        begin
            dirty_next = dirty_next & ~vict_sel;
        end
        if (cmd.emit_flush_wb)
        begin
            dirty_next = dirty_next & ~walk_sel;
        end
        if (cmd.emit_hit && req_write)
        begin
            dirty_next = dirty_next | hit_vec_reg;
        end
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            if (cmd.emit_place && vict_sel[i])
            begin
                valid_next[i] = 1'b1;
                dirty_next[i] = req_write;
                file_next[i]  = req_file_reg;
                page_next[i]  = req_page_reg;
            end
            if (move_en)
            begin
                if (front_sel[i])
                begin
                    rank_next[i] = '0;
                end
                else if (rank_reg[i] < front_rank)
                begin
                    rank_next[i] = rank_reg[i] + 1'b1;
                end
            end
        end
    end

    // lookup and walk registers
    always_comb
    begin
        hit_vec_next   = hit_vec_reg;
        hit_next       = hit_reg;
        all_dirty_next = all_dirty_reg;
        vrank_next     = vrank_reg;
        walk_next      = walk_reg;
        if (cmd.do_lookup)
        begin
            hit_vec_next   = hit_vec;
            hit_next       = |hit_vec;
            all_dirty_next = !clean_found;
            vrank_next     = clean_found ? first_clean : LAST_RANK;
        end
        if (cmd.walk_clear)
        begin
            walk_next = '0;
        end
        else if (cmd.walk_inc)
        begin
            walk_next = walk_reg + 1'b1;
        end
    end

    // result register
    assign emit_any = cmd.emit_hit | cmd.emit_lru_wb | cmd.emit_place
                    | cmd.emit_flush_wb | cmd.emit_flush_done;

    always_comb
    begin
        out_valid_next = out_valid_reg & ~out_ready;
        kind_next      = kind_reg;
        entry_next     = entry_reg;
        tfile_next     = tfile_reg;
        tpage_next     = tpage_reg;
        last_next      = last_reg;
        if (emit_any)
        begin
            out_valid_next = 1'b1;
        end
        if (cmd.emit_hit)
        begin
            kind_next  = KIND_HIT;
            entry_next = ENTRY_W'(hit_idx);
            tfile_next = req_file_reg;
            tpage_next = req_page_reg;
            last_next  = 1'b1;
        end
        else if (cmd.emit_lru_wb)
        begin
            kind_next  = KIND_WRITEBACK;
            entry_next = ENTRY_W'(vict_idx);
            tfile_next = vict_file;
            tpage_next = vict_page;
            last_next  = 1'b0;
        end
        else if (cmd.emit_place)
        begin
            kind_next  = req_write ? KIND_TAKE : KIND_FILL;
            entry_next = ENTRY_W'(vict_idx);
            tfile_next = req_file_reg;
            tpage_next = req_page_reg;
            last_next  = 1'b1;
        end
        else if (cmd.emit_flush_wb)
        begin
            kind_next  = KIND_WRITEBACK;
            entry_next = ENTRY_W'(walk_idx);
            tfile_next = walk_file;
            tpage_next = walk_page;
            last_next  = 1'b0;
        end
        else if (cmd.emit_flush_done)
        begin
            kind_next  = KIND_FLUSH_DONE;
            entry_next = '0;
            tfile_next = req_file_reg;
            tpage_next = '0;
            last_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            dirty_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                file_reg[i] <= '0;
                page_reg[i] <= '0;
                rank_reg[i] <= IDX_W'(i);
            end
        end
        else
        begin
            valid_reg     <= valid_next;
            dirty_reg     <= dirty_next;
            file_reg      <= file_next;
            page_reg      <= page_next;
            rank_reg      <= rank_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_req)
        begin
            req_mode_reg <= mode_t'(mode);
            req_file_reg <= file_id;
            req_page_reg <= page_number;
        end
        hit_vec_reg   <= hit_vec_next;
        hit_reg       <= hit_next;
        all_dirty_reg <= all_dirty_next;
        vrank_reg     <= vrank_next;
        walk_reg      <= walk_next;
        kind_reg      <= kind_next;
        entry_reg     <= entry_next;
        tfile_reg     <= tfile_next;
        tpage_reg     <= tpage_next;
        last_reg      <= last_next;
    end

    assign status.in_mode    = mode_t'(mode);
    assign status.hit        = hit_reg;
    assign status.all_dirty  = all_dirty_reg;
    assign status.walk_match = |(walk_sel & file_eq);
    assign status.walk_last  = (walk_reg == LAST_RANK);
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign entry       = entry_reg;
    assign target_file = tfile_reg;
    assign target_page = tpage_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

// ===== rtl/pblw_ctrl.sv =====
// pblw_ctrl: request sequencer, drives datapath commands from its status
// depends on pblw_pkg
`default_nettype none

module pblw_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pblw_pkg::status_t status,
    output pblw_pkg::cmd_t    cmd
);
    import pblw_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE       = 6'b000001,
        S_LOOKUP     = 6'b000010,
        S_RESOLVE    = 6'b000100,
        S_PLACE      = 6'b001000,
        S_FLUSH_SCAN = 6'b010000,
        S_FLUSH_DONE = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_req = 1'b1;
                    if (status.in_mode == MODE_FLUSH)
                    begin
                        cmd.walk_clear = 1'b1;
                        state_next     = S_FLUSH_SCAN;
                    end
                    else if (status.in_mode != MODE_NONE)
                    begin
                        state_next = S_LOOKUP;
                    end
                end
            end
            S_LOOKUP:
            begin
                cmd.do_lookup = 1'b1;
                state_next    = S_RESOLVE;
            end
            S_RESOLVE:
            begin
                if (status.out_free)
                begin
                    if (status.hit)
                    begin
                        cmd.emit_hit = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else if (status.all_dirty)
                    begin
                        cmd.emit_lru_wb = 1'b1;
                        state_next      = S_PLACE;
                    end
                    else
                    begin
                        cmd.emit_place = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
            end
            S_PLACE:
            begin
                if (status.out_free)
                begin
                    cmd.emit_place = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_FLUSH_SCAN:
            begin
                if (!status.walk_match || status.out_free)
                begin
                    cmd.emit_flush_wb = status.walk_match;
                    cmd.walk_inc      = 1'b1;
                    if (status.walk_last)
                    begin
                        state_next = S_FLUSH_DONE;
                    end
                end
            end
            S_FLUSH_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.emit_flush_done = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/page_buffer_lru_writeback_top.sv =====
// page_buffer_lru_writeback_top: tag and recency policy controller for a small
// fully associative page buffer pool, sequencer plus datapath
// depends on pblw_pkg, pblw_ctrl, pblw_datapath
//
//   channel   | signals                                      | direction
//   ----------+----------------------------------------------+----------
//   request   | in_valid, in_ready, mode, file_id,           | in
//             | page_number                                  |
//   result    | out_valid, out_ready, kind, entry,           | out
//             | target_file, target_page, last               |
//
// one request at a time; the sequencer takes a request only when idle
// read/write hit or clean miss: accept, lookup, then the hit or the fill/take; a
// miss with every entry dirty adds the write back of the least recent entry first
// flush: one scan step per recency rank walked by the scan, then the flush done
// an unused mode is only accepted and changes nothing
// results sit in a single output register; a stalled result only holds the
// sequencer when it has a further result to issue
// reset: all entries unused and clean, entry i at recency rank i
`default_nettype none

module page_buffer_lru_writeback_top #(
    parameter int NUM_ENTRIES = pblw_pkg::DEF_NUM_ENTRIES
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // request channel
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [pblw_pkg::MODE_W-1:0]  mode,
    input  logic [pblw_pkg::FILE_W-1:0]  file_id,
    input  logic [pblw_pkg::PAGE_W-1:0]  page_number,
    // result channel
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [pblw_pkg::KIND_W-1:0]  kind,
    output logic [pblw_pkg::ENTRY_W-1:0] entry,
    output logic [pblw_pkg::FILE_W-1:0]  target_file,
    output logic [pblw_pkg::PAGE_W-1:0]  target_page,
    output logic                         last
);
    import pblw_pkg::*;

    // command and status between sequencer and datapath
    cmd_t    cmd;
    status_t status;

    // sequencer: lookup, then hit / write back / fill or take, or the flush
    // walk over recency ranks from most to least recent
    pblw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: tags, dirty bits, per-entry recency ranks, victim choice
    // (most recent clean entry, else the least recent one) and the result
    // register
    pblw_datapath #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .mode        (mode),
        .file_id     (file_id),
        .page_number (page_number),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .kind        (kind),
        .entry       (entry),
        .target_file (target_file),
        .target_page (target_page),
        .last        (last)
    );

endmodule

`default_nettype wire
